>>> design/rosh_pkg.sv
// Shared constants and types of the ray versus oriented-box hit test.
`timescale 1ns / 1ps
package rosh_pkg;

  localparam int unsigned CompBitsDef = 20;
  localparam int unsigned TolW = 37;
  localparam logic [TolW-1:0] TolReset = 37'd687195;

  typedef enum logic [1:0] {
    ReasonTested  = 2'd0,
    ReasonBadBox  = 2'd1,
    ReasonZeroDir = 2'd2
  } reason_e;

  typedef struct packed {
    logic    valid;
    reason_e reason;
  } rosh_tag_t;

endpackage

>>> design/rosh_front.sv
// Front part: unpack the beat, check the box and direction, form slab start and speed.
`timescale 1ns / 1ps
module rosh_front #(
  parameter int unsigned CB = rosh_pkg::CompBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [rosh_pkg::TolW-1:0]  tol_i,
  input  logic [3*CB-1:0]            ray_origin_i,
  input  logic [3*CB-1:0]            ray_direction_i,
  input  logic [3*CB-1:0]            box_center_i,
  input  logic [3*CB-1:0]            box_axis_first_i,
  input  logic [3*CB-1:0]            box_axis_second_i,
  input  logic [3*CB-1:0]            box_axis_third_i,
  input  logic [3*CB-1:0]            box_half_extent_i,
  output rosh_pkg::rosh_tag_t        tag_o,
  output logic [3*(2*CB+2)-1:0]      s_o,
  output logic [3*(2*CB+1)-1:0]      v_o,
  output logic [3*CB-1:0]            he_o
);

  localparam int unsigned DW = 2 * CB + 1;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned AF = CB - 2;
  localparam int unsigned CW = (2 * CB + 2 > rosh_pkg::TolW + 1) ? 2 * CB + 2
                                                                 : rosh_pkg::TolW + 1;
  localparam logic signed [CW-1:0] One = {{(CW - 1){1'b0}}, 1'b1} << (2 * AF);

  function automatic logic signed [DW-1:0] dot_c(
    input logic signed [CB-1:0] a0, input logic signed [CB-1:0] a1,
    input logic signed [CB-1:0] a2, input logic signed [CB-1:0] b0,
    input logic signed [CB-1:0] b1, input logic signed [CB-1:0] b2);
    logic signed [2*CB-1:0] p0, p1, p2;
    p0 = a0 * b0;
    p1 = a1 * b1;
    p2 = a2 * b2;
    return DW'(p0) + DW'(p1) + DW'(p2);
  endfunction

  function automatic logic signed [SW-1:0] dot_o(
    input logic signed [CB:0] a0, input logic signed [CB:0] a1,
    input logic signed [CB:0] a2, input logic signed [CB-1:0] b0,
    input logic signed [CB-1:0] b1, input logic signed [CB-1:0] b2);
    logic signed [2*CB:0] p0, p1, p2;
    logic signed [2*CB:0] e0, e1, e2;
    e0 = (2*CB+1)'(b0);
    e1 = (2*CB+1)'(b1);
    e2 = (2*CB+1)'(b2);
    p0 = (2*CB+1)'(a0) * e0;
    p1 = (2*CB+1)'(a1) * e1;
    p2 = (2*CB+1)'(a2) * e2;
    return SW'(p0) + SW'(p1) + SW'(p2);
  endfunction

  function automatic logic over_tol(input logic signed [CW-1:0] x,
                                    input logic [rosh_pkg::TolW-1:0] tol);
    logic [CW-1:0] m;
    m = x[CW-1] ? CW'(-x) : CW'(x);
    return m > CW'(tol);
  endfunction

  logic signed [CB-1:0] org_c [3];
  logic signed [CB-1:0] dir_c [3];
  logic signed [CB-1:0] ctr_c [3];
  logic signed [CB-1:0] he_c  [3];
  logic signed [CB-1:0] ax_c  [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      org_c[k]    = ray_origin_i[k*CB +: CB];
      dir_c[k]    = ray_direction_i[k*CB +: CB];
      ctr_c[k]    = box_center_i[k*CB +: CB];
      he_c[k]     = box_half_extent_i[k*CB +: CB];
      ax_c[0][k]  = box_axis_first_i[k*CB +: CB];
      ax_c[1][k]  = box_axis_second_i[k*CB +: CB];
      ax_c[2][k]  = box_axis_third_i[k*CB +: CB];
    end
  end

  // First stage: axis dot products and ray offset.
  logic                 v1_q;
  logic signed [CB:0]   off_q [3];
  logic signed [CB-1:0] dir_q [3];
  logic signed [CB-1:0] he_q  [3];
  logic signed [CB-1:0] ax_q  [3][3];
  logic signed [DW-1:0] aa_q  [3];
  logic signed [DW-1:0] ab_q  [3];
  logic                 dirz_q;
  logic                 heneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      off_q[k] <= (CB+1)'(org_c[k]) - (CB+1)'(ctr_c[k]);
      dir_q[k] <= dir_c[k];
      he_q[k]  <= he_c[k];
      for (int a = 0; a < 3; a++) begin
        ax_q[a][k] <= ax_c[a][k];
      end
      aa_q[k] <= dot_c(ax_c[k][0], ax_c[k][1], ax_c[k][2],
                       ax_c[k][0], ax_c[k][1], ax_c[k][2]);
    end
    ab_q[0] <= dot_c(ax_c[0][0], ax_c[0][1], ax_c[0][2], ax_c[1][0], ax_c[1][1], ax_c[1][2]);
    ab_q[1] <= dot_c(ax_c[0][0], ax_c[0][1], ax_c[0][2], ax_c[2][0], ax_c[2][1], ax_c[2][2]);
    ab_q[2] <= dot_c(ax_c[1][0], ax_c[1][1], ax_c[1][2], ax_c[2][0], ax_c[2][1], ax_c[2][2]);
    dirz_q  <= (ray_direction_i == '0);
    heneg_q <= he_c[0][CB-1] | he_c[1][CB-1] | he_c[2][CB-1];
  end

  // Second stage: classify, and project offset and direction on the axes.
  logic              bad_c;
  rosh_pkg::reason_e reason_c;

  always_comb begin
    bad_c = heneg_q;
    for (int k = 0; k < 3; k++) begin
      bad_c = bad_c | over_tol(CW'(aa_q[k]) - One, tol_i) | over_tol(CW'(ab_q[k]), tol_i);
    end
    if (bad_c) begin
      reason_c = rosh_pkg::ReasonBadBox;
    end else if (dirz_q) begin
      reason_c = rosh_pkg::ReasonZeroDir;
    end else begin
      reason_c = rosh_pkg::ReasonTested;
    end
  end

  logic                tv_q;
  rosh_pkg::reason_e   tr_q;
  logic [3*SW-1:0]     s_q;
  logic [3*DW-1:0]     v_q;
  logic [3*CB-1:0]     he2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else begin
      tv_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tr_q <= reason_c;
    for (int k = 0; k < 3; k++) begin
      s_q[k*SW +: SW] <= dot_o(off_q[0], off_q[1], off_q[2],
                               ax_q[k][0], ax_q[k][1], ax_q[k][2]);
      v_q[k*DW +: DW] <= dot_c(dir_q[0], dir_q[1], dir_q[2],
                               ax_q[k][0], ax_q[k][1], ax_q[k][2]);
      he2_q[k*CB +: CB] <= he_q[k];
    end
  end

  assign tag_o = {tv_q, tr_q};
  assign s_o   = s_q;
  assign v_o   = v_q;
  assign he_o  = he2_q;

endmodule

>>> design/rosh_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module rosh_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic         full_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         pop;

  // The back part never stalls: drain one beat whenever there is one.
  assign pop = (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);

endmodule

>>> design/rosh_back.sv
// Back part: slab bounds, cross products of entry and exit fractions, hit decision.
`timescale 1ns / 1ps
module rosh_back #(
  parameter int unsigned CB = rosh_pkg::CompBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rosh_pkg::rosh_tag_t      tag_i,
  input  logic [3*(2*CB+2)-1:0]    s_i,
  input  logic [3*(2*CB+1)-1:0]    v_i,
  input  logic [3*CB-1:0]          he_i,
  output logic                     done_o,
  output logic                     hit_o,
  output rosh_pkg::reason_e        reason_o
);

  localparam int unsigned DW = 2 * CB + 1;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned AF = CB - 2;
  localparam int unsigned PW = SW + CB + 1;
  localparam int unsigned FW = PW + CB + 1;

  function automatic logic signed [PW-1:0] mulp(input logic signed [SW-1:0] a,
                                                input logic [CB-1:0] b);
    logic signed [PW-1:0] ae, be;
    ae = PW'(a);
    be = PW'($signed({1'b0, b}));
    return ae * be;
  endfunction

  // Stage 1: entry and exit numerators, speed magnitude, parallel slabs.
  logic signed [SW-1:0] s_c [3];
  logic signed [DW-1:0] v_c [3];
  logic signed [CB-1:0] he_c [3];
  logic signed [SW-1:0] e_c [3];
  logic signed [SW-1:0] lo_c [3];
  logic signed [SW-1:0] hi_c [3];
  logic [DW-1:0]        va_c [3];
  logic [2*CB-1:0]      d_c [3];
  logic [2:0]           par_c;
  logic                 miss_c;

  always_comb begin
    miss_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      s_c[k]  = s_i[k*SW +: SW];
      v_c[k]  = v_i[k*DW +: DW];
      he_c[k] = he_i[k*CB +: CB];
      e_c[k]  = SW'(he_c[k]) <<< AF;
      par_c[k] = (v_c[k] == '0);
      va_c[k] = v_c[k][DW-1] ? DW'(-v_c[k]) : DW'(v_c[k]);
      d_c[k]  = va_c[k][2*CB-1:0];
      if (v_c[k][DW-1]) begin
        lo_c[k] = s_c[k] - e_c[k];
        hi_c[k] = s_c[k] + e_c[k];
      end else begin
        lo_c[k] = -e_c[k] - s_c[k];
        hi_c[k] = e_c[k] - s_c[k];
      end
      // Parallel slab: miss when outside. Otherwise exit behind the origin misses.
      if (par_c[k]) begin
        miss_c = miss_c | (s_c[k] > e_c[k]) | (s_c[k] < -e_c[k]);
      end else begin
        miss_c = miss_c | hi_c[k][SW-1];
      end
    end
  end

  logic                 v1_q;
  rosh_pkg::reason_e    r1_q;
  logic signed [SW-1:0] lo_q [3];
  logic signed [SW-1:0] hi_q [3];
  logic [2*CB-1:0]      d_q [3];
  logic [2:0]           par1_q;
  logic                 miss1_q;

  // Stage 2: partial products of the cross compares.
  logic                 v2_q;
  rosh_pkg::reason_e    r2_q;
  logic [2:0]           par2_q;
  logic                 miss2_q;
  logic signed [PW-1:0] pah_q [3][3];
  logic signed [PW-1:0] pal_q [3][3];
  logic signed [PW-1:0] pbh_q [3][3];
  logic signed [PW-1:0] pbl_q [3][3];

  // Stage 3: entry of slab i must not pass exit of slab j.
  logic signed [FW-1:0] lhs_c, rhs_c;
  logic                 ok_c;

  always_comb begin
    ok_c  = 1'b1;
    lhs_c = '0;
    rhs_c = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i != j) begin
          lhs_c = (FW'(pah_q[i][j]) <<< CB) + FW'(pal_q[i][j]);
          rhs_c = (FW'(pbh_q[i][j]) <<< CB) + FW'(pbl_q[i][j]);
          ok_c  = ok_c & (par2_q[i] | par2_q[j] | (lhs_c <= rhs_c));
        end
      end
    end
  end

  logic              done_q;
  logic              hit_q;
  rosh_pkg::reason_e reason_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= tag_i.valid;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q    <= tag_i.reason;
    par1_q  <= par_c;
    miss1_q <= miss_c;
    for (int k = 0; k < 3; k++) begin
      lo_q[k] <= lo_c[k];
      hi_q[k] <= hi_c[k];
      d_q[k]  <= d_c[k];
    end
    r2_q    <= r1_q;
    par2_q  <= par1_q;
    miss2_q <= miss1_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pah_q[i][j] <= mulp(lo_q[i], d_q[j][2*CB-1:CB]);
        pal_q[i][j] <= mulp(lo_q[i], d_q[j][CB-1:0]);
        pbh_q[i][j] <= mulp(hi_q[j], d_q[i][2*CB-1:CB]);
        pbl_q[i][j] <= mulp(hi_q[j], d_q[i][CB-1:0]);
      end
    end
    reason_q <= r2_q;
    hit_q    <= (r2_q == rosh_pkg::ReasonTested) & ~miss2_q & ok_c;
  end

  assign done_o   = done_q;
  assign hit_o    = hit_q;
  assign reason_o = reason_q;

endmodule

>>> design/ray_obb_slab_hit_test_core.sv
// Top level of the ray versus oriented-box slab hit test.
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+---------------------------
//  item in   | ray_*_i, box_*_i                                 | start_i high, busy_o low
//  result    | hit_o, reject_reason_o                           | done_o, one cycle, no stall
//  config    | tol_wdata_i                                      | tol_we_i high
//
// One beat is taken per cycle while busy_o is low; each result shows done_o after its beat
// passes two front stages (axis dots, then classify and project), one queue stage, and
// three back stages (slab bounds, partial products, compare).
// The back part drains the queue every cycle, so busy_o stays low in practice.
// Reset clears all valid flags and loads the default tolerance.
`timescale 1ns / 1ps
module ray_obb_slab_hit_test_core #(
  parameter int unsigned COMPONENT_BITS = rosh_pkg::CompBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [3*COMPONENT_BITS-1:0]   ray_origin_i,
  input  logic [3*COMPONENT_BITS-1:0]   ray_direction_i,
  input  logic [3*COMPONENT_BITS-1:0]   box_center_i,
  input  logic [3*COMPONENT_BITS-1:0]   box_axis_first_i,
  input  logic [3*COMPONENT_BITS-1:0]   box_axis_second_i,
  input  logic [3*COMPONENT_BITS-1:0]   box_axis_third_i,
  input  logic [3*COMPONENT_BITS-1:0]   box_half_extent_i,
  input  logic                          tol_we_i,
  input  logic [rosh_pkg::TolW-1:0]     tol_wdata_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [1:0]                    reject_reason_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned DW = 2 * CB + 1;
  localparam int unsigned QW = 2 + 3 * SW + 3 * DW + 3 * CB;

  logic [rosh_pkg::TolW-1:0] tol_q;

  // Hold the tolerance; write it only while idle. The block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= rosh_pkg::TolReset;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  logic                take;
  logic                q_full;
  rosh_pkg::rosh_tag_t f_tag;
  logic [3*SW-1:0]     f_s;
  logic [3*DW-1:0]     f_v;
  logic [3*CB-1:0]     f_he;
  logic [QW-1:0]       q_in, q_out;
  logic                q_valid;
  rosh_pkg::rosh_tag_t b_tag;
  rosh_pkg::reason_e   b_reason;

  assign take = start_i & ~busy_o;

  rosh_front #(.CB(CB)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .take_i            (take),
    .tol_i             (tol_q),
    .ray_origin_i      (ray_origin_i),
    .ray_direction_i   (ray_direction_i),
    .box_center_i      (box_center_i),
    .box_axis_first_i  (box_axis_first_i),
    .box_axis_second_i (box_axis_second_i),
    .box_axis_third_i  (box_axis_third_i),
    .box_half_extent_i (box_half_extent_i),
    .tag_o             (f_tag),
    .s_o               (f_s),
    .v_o               (f_v),
    .he_o              (f_he)
  );

  assign q_in = {f_tag.reason, f_s, f_v, f_he};

  rosh_queue #(.W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_tag.valid),
    .data_i  (q_in),
    .valid_o (q_valid),
    .data_o  (q_out),
    .full_o  (q_full)
  );

  assign b_tag = {q_valid, q_out[QW-1 -: 2]};

  rosh_back #(.CB(CB)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (b_tag),
    .s_i      (q_out[3*DW+3*CB +: 3*SW]),
    .v_i      (q_out[3*CB +: 3*DW]),
    .he_i     (q_out[3*CB-1:0]),
    .done_o   (done_o),
    .hit_o    (hit_o),
    .reason_o (b_reason)
  );

  assign busy_o          = q_full;
  assign reject_reason_o = b_reason;

endmodule

>>> design/rosh_chk.sv
// Port-level checker of the hit test core, bound to the top level.
`timescale 1ns / 1ps
module rosh_chk #(
  parameter int unsigned CB = rosh_pkg::CompBitsDef
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic [3*CB-1:0] ray_direction_i,
  input logic            done_o,
  input logic            hit_o,
  input logic [1:0]      reject_reason_o
);

  // Every taken beat gives a result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##6 done_o)
    else $error("result missing after taken beat");

  // No result without an earlier taken beat.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 6))
    else $error("result without a taken beat");

  // A rejected item never reports a hit.
  a_reject_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && reject_reason_o != rosh_pkg::ReasonTested |-> !hit_o)
    else $error("hit on rejected item");

  // A zero direction is never tested normally.
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(ray_direction_i, 6) == '0 |-> reject_reason_o != rosh_pkg::ReasonTested)
    else $error("zero direction tested");

endmodule

bind ray_obb_slab_hit_test_core rosh_chk #(.CB(COMPONENT_BITS)) u_rosh_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .ray_direction_i (ray_direction_i),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .reject_reason_o (reject_reason_o)
);

>>> sim/ray_obb_slab_hit_test_core_tb.sv
// Self-checking testbench for the ray versus oriented-box slab hit test core.
`timescale 1ns / 1ps
module ray_obb_slab_hit_test_core_tb;
  import rosh_pkg::*;

  localparam int unsigned CB = CompBitsDef;
  localparam int unsigned AF = CB - 2;
  localparam int unsigned WW = 3 * CB;
  localparam longint UNIT = longint'(1) << AF;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic    hit;
    reason_e reason;
  } verdict_t;

  typedef struct {
    logic [WW-1:0] org, dir, ctr, ax0, ax1, ax2, he;
  } ray_box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [WW-1:0] ray_origin_i = '0;
  logic [WW-1:0] ray_direction_i = '0;
  logic [WW-1:0] box_center_i = '0;
  logic [WW-1:0] box_axis_first_i = '0;
  logic [WW-1:0] box_axis_second_i = '0;
  logic [WW-1:0] box_axis_third_i = '0;
  logic [WW-1:0] box_half_extent_i = '0;
  logic tol_we_i = 1'b0;
  logic [TolW-1:0] tol_wdata_i = '0;
  logic done_o;
  logic hit_o;
  logic [1:0] reject_reason_o;

  ray_obb_slab_hit_test_core u_top (.*);

  // Predictor copy of the tolerance register; updated on the write edge.
  logic [TolW-1:0] tol_shadow = TolReset;
  verdict_t verdict_q[$];
  int unsigned beats_taken = 0;
  int unsigned errors = 0;
  int unsigned n_hit = 0, n_miss = 0, n_badbox = 0, n_zerodir = 0;
  int unsigned stall_cycles = 0;
  bit idle_allowed = 1'b1;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer slab clip.
  // ---------------------------------------------------------------------------
  function automatic longint comp_of(logic [WW-1:0] w, int k);
    logic signed [CB-1:0] c;
    c = w[k*CB +: CB];
    return longint'(c);
  endfunction

  function automatic longint dot_of(logic [WW-1:0] a, logic [WW-1:0] b);
    return comp_of(a, 0) * comp_of(b, 0) + comp_of(a, 1) * comp_of(b, 1)
         + comp_of(a, 2) * comp_of(b, 2);
  endfunction

  function automatic longint abs_of(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Sign of a/b - c/d with positive denominators, exact in 128 bits.
  function automatic int frac_order(longint a, longint b, longint c, longint d);
    logic signed [127:0] lhs, rhs;
    lhs = 128'(signed'(a)) * 128'(signed'(d));
    rhs = 128'(signed'(c)) * 128'(signed'(b));
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic verdict_t predict_hit(ray_box_t it, logic [TolW-1:0] tol);
    verdict_t v;
    logic [WW-1:0] axes[3];
    longint one, t, s, spd, ext, lo, hi, dn, low_n, low_d, up_n, up_d;
    longint off[3];
    bit up_set, ok;
    axes[0] = it.ax0;
    axes[1] = it.ax1;
    axes[2] = it.ax2;
    one = longint'(1) << (2 * AF);
    t = longint'(tol);
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (comp_of(it.he, i) < 0) ok = 1'b0;
      if (abs_of(dot_of(axes[i], axes[i]) - one) > t) ok = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (abs_of(dot_of(axes[i], axes[j])) > t) ok = 1'b0;
      end
    end
    v.hit = 1'b0;
    if (!ok) begin
      v.reason = ReasonBadBox;
      return v;
    end
    if (it.dir == '0) begin
      v.reason = ReasonZeroDir;
      return v;
    end
    v.reason = ReasonTested;
    v.hit = 1'b1;
    for (int i = 0; i < 3; i++) off[i] = comp_of(it.org, i) - comp_of(it.ctr, i);
    low_n = 0; low_d = 1; up_n = 0; up_d = 1; up_set = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = off[0] * comp_of(axes[i], 0) + off[1] * comp_of(axes[i], 1)
        + off[2] * comp_of(axes[i], 2);
      spd = dot_of(it.dir, axes[i]);
      ext = comp_of(it.he, i) * UNIT;
      if (spd == 0) begin
        // Parallel slab: outside means miss, inside leaves interval alone.
        if (abs_of(s) > ext) v.hit = 1'b0;
        continue;
      end
      if (spd > 0) begin
        lo = -ext - s; hi = ext - s; dn = spd;
      end else begin
        lo = s - ext; hi = s + ext; dn = -spd;
      end
      if (frac_order(lo, dn, low_n, low_d) > 0) begin
        low_n = lo; low_d = dn;
      end
      if (!up_set || frac_order(hi, dn, up_n, up_d) < 0) begin
        up_n = hi; up_d = dn; up_set = 1'b1;
      end
    end
    if (up_set && frac_order(low_n, low_d, up_n, up_d) > 0) v.hit = 1'b0;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat acceptance, tolerance shadow, and result checking at the rising edge.
  // Flop outputs still hold pre-edge values here, so sampling is race free.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ray_box_t it;
    verdict_t want;
    if (rst_ni) begin
      if (tol_we_i) tol_shadow = tol_wdata_i;
      if (start_i && !busy_o) begin
        it.org = ray_origin_i;       it.dir = ray_direction_i;
        it.ctr = box_center_i;       it.ax0 = box_axis_first_i;
        it.ax1 = box_axis_second_i;  it.ax2 = box_axis_third_i;
        it.he  = box_half_extent_i;
        want = predict_hit(it, tol_shadow);
        verdict_q = {verdict_q, want};
        beats_taken++;
        case (want.reason)
          ReasonBadBox:  n_badbox++;
          ReasonZeroDir: n_zerodir++;
          default: begin
            if (want.hit) n_hit++;
            else n_miss++;
          end
        endcase
      end
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result hit=%0b reason=%0d", $time, hit_o,
                   reject_reason_o);
        end else begin
          want = verdict_q.pop_front();
          if (hit_o !== want.hit) begin
            errors++;
            $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, hit_o);
          end
          if (reject_reason_o !== want.reason) begin
            errors++;
            $display("%0t: reject_reason mismatch expected %0d actual %0d", $time,
                     want.reason, reject_reason_o);
          end
        end
      end
    end
  end

  // Watchdog: stop if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni || tol_we_i) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time, verdict_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All driving happens at the falling edge.
  // ---------------------------------------------------------------------------
  function automatic logic [WW-1:0] pack3(longint x, longint y, longint z);
    logic [CB-1:0] cx, cy, cz;
    cx = x[CB-1:0];
    cy = y[CB-1:0];
    cz = z[CB-1:0];
    return {cz, cy, cx};
  endfunction

  function automatic longint rand_comp(int unsigned span);
    return longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  function automatic logic [WW-1:0] rand_word();
    return WW'({$urandom(), $urandom()});
  endfunction

  // Hold start and the payload until the beat is taken.
  task automatic send_beat(ray_box_t it);
    int unsigned target;
    ray_origin_i = it.org;       ray_direction_i = it.dir;
    box_center_i = it.ctr;       box_axis_first_i = it.ax0;
    box_axis_second_i = it.ax1;  box_axis_third_i = it.ax2;
    box_half_extent_i = it.he;
    start_i = 1'b1;
    target = beats_taken + 1;
    while (beats_taken < target) @(negedge clk_i);
    // Now and then drop start for a random gap before the next beat.
    if (idle_allowed && $urandom_range(99) < 5) begin
      start_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
  endtask

  // Drain everything in flight, then let the pipeline settle.
  task automatic drain_all();
    start_i = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_tol(logic [TolW-1:0] value);
    drain_all();
    tol_we_i = 1'b1;
    tol_wdata_i = value;
    @(negedge clk_i);
    tol_we_i = 1'b0;
  endtask

  // Rotated, permuted and sign-flipped unit frame; optional small skew.
  task automatic make_frame(output logic [WW-1:0] a0, output logic [WW-1:0] a1,
                            output logic [WW-1:0] a2, input int unsigned skew);
    real ang;
    longint c, s;
    longint m[3][3];
    int unsigned rot;
    ang = $urandom_range(6283) / 1000.0;
    c = longint'($floor($cos(ang) * UNIT + 0.5));
    s = longint'($floor($sin(ang) * UNIT + 0.5));
    if ($urandom_range(3) == 0) begin
      c = UNIT;
      s = 0;
    end
    m[0][0] = c;  m[0][1] = s; m[0][2] = 0;
    m[1][0] = -s; m[1][1] = c; m[1][2] = 0;
    m[2][0] = 0;  m[2][1] = 0; m[2][2] = UNIT;
    rot = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      longint r0, r1, r2;
      r0 = m[i][(0 + rot) % 3];
      r1 = m[i][(1 + rot) % 3];
      r2 = m[i][(2 + rot) % 3];
      if ($urandom_range(1)) begin
        r0 = -r0; r1 = -r1; r2 = -r2;
      end
      m[i][0] = r0 + ((skew != 0) ? rand_comp(skew) : 0);
      m[i][1] = r1;
      m[i][2] = r2;
    end
    a0 = pack3(m[0][0], m[0][1], m[0][2]);
    a1 = pack3(m[1][0], m[1][1], m[1][2]);
    a2 = pack3(m[2][0], m[2][1], m[2][2]);
  endtask

  // One random beat: mostly well-formed boxes, some broken boxes and raw noise.
  task automatic random_beat();
    ray_box_t it;
    int unsigned pick, span, skew;
    pick = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 500000 : 8000;
    skew = ($urandom_range(4) == 0) ? $urandom_range(8) : 0;
    make_frame(it.ax0, it.ax1, it.ax2, skew);
    it.org = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
    it.ctr = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
    it.he = pack3($urandom_range(span), $urandom_range(span), $urandom_range(span));
    it.dir = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
    // Aim at the box center half the time so hits are common.
    if ($urandom_range(1)) begin
      it.dir = pack3(comp_of(it.ctr, 0) - comp_of(it.org, 0),
                     comp_of(it.ctr, 1) - comp_of(it.org, 1),
                     comp_of(it.ctr, 2) - comp_of(it.org, 2));
    end
    // Zero some direction components to exercise parallel slabs.
    if ($urandom_range(4) == 0) begin
      it.dir[$urandom_range(2)*CB +: CB] = '0;
      if ($urandom_range(1)) it.dir[$urandom_range(2)*CB +: CB] = '0;
    end
    if (pick < 4) it.dir = '0;
    else if (pick < 8) it.he[$urandom_range(2)*CB + CB - 1] = 1'b1;
    else if (pick < 16) begin
      it.org = rand_word(); it.dir = rand_word(); it.ctr = rand_word();
      it.ax0 = rand_word(); it.ax1 = rand_word(); it.ax2 = rand_word();
      it.he = rand_word();
    end
    send_beat(it);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  function automatic ray_box_t unit_box();
    ray_box_t it;
    it.ax0 = pack3(UNIT, 0, 0);
    it.ax1 = pack3(0, UNIT, 0);
    it.ax2 = pack3(0, 0, UNIT);
    it.ctr = '0;
    it.he = pack3(1024, 1024, 1024);
    it.org = pack3(-4096, 0, 0);
    it.dir = pack3(1024, 0, 0);
    return it;
  endfunction

  task automatic test_slab_cases();
    ray_box_t it;
    it = unit_box();
    send_beat(it);                              // straight through
    it.dir = pack3(-1024, 0, 0); send_beat(it); // pointing away
    it = unit_box(); it.org = pack3(0, 0, 0); it.dir = pack3(0, 0, 5);
    send_beat(it);                              // starting inside
    it = unit_box(); it.org = pack3(-4096, 1024, 0);
    send_beat(it);                              // grazing a face, parallel slab
    it.org = pack3(-4096, 1025, 0); send_beat(it);
    it = unit_box(); it.org = pack3(-2048, 0, 0); it.dir = pack3(1024, 1024, 0);
    send_beat(it);                              // corner touch: entry equals exit
    it.org = pack3(-2049, 0, 0); send_beat(it);
    it = unit_box(); it.org = pack3(0, 0, 0); it.dir = pack3(0, 0, 0);
    send_beat(it);                              // zero direction
    it = unit_box(); it.he = pack3(1024, -1, 1024);
    send_beat(it);                              // negative half extent
    it = unit_box(); it.he = '0; it.org = '0; it.dir = pack3(1, 1, 1);
    send_beat(it);                              // degenerate point box
    it = unit_box(); it.ax1 = pack3(UNIT, 0, 0);
    send_beat(it);                              // axes not orthogonal
    it = unit_box(); it.ax2 = pack3(0, 0, UNIT + 3);
    send_beat(it);                              // axis slightly long
  endtask

  task automatic test_field_extremes();
    ray_box_t it;
    logic [WW-1:0] pats[4];
    pats[0] = '0;
    pats[1] = '1;
    pats[2] = pack3((1 << (CB - 1)) - 1, (1 << (CB - 1)) - 1, (1 << (CB - 1)) - 1);
    pats[3] = pack3(-(1 << (CB - 1)), -(1 << (CB - 1)), -(1 << (CB - 1)));
    for (int p = 0; p < 4; p++) begin
      it.org = pats[p]; it.dir = pats[3 - p]; it.ctr = pats[(p + 1) % 4];
      it.ax0 = pats[p]; it.ax1 = pats[p]; it.ax2 = pats[p]; it.he = pats[p];
      send_beat(it);
      it = unit_box();
      it.org = pats[p]; it.dir = pats[(p + 2) % 4]; it.ctr = pats[3 - p];
      it.he = pack3((1 << (CB - 1)) - 1, (1 << (CB - 1)) - 1, (1 << (CB - 1)) - 1);
      send_beat(it);
    end
  endtask

  task automatic test_random_stream(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      // Keep a long stretch free of gaps in the middle of the stream.
      idle_allowed = !(n >= count / 3 && n < count / 2);
      random_beat();
    end
    idle_allowed = 1'b1;
  endtask

  task automatic test_tolerance_settings();
    write_tol('0);
    test_random_stream(200);
    write_tol({TolW{1'b1}});
    test_random_stream(150);
    write_tol(TolW'($urandom_range(2000000)));
    test_random_stream(150);
    write_tol(TolReset);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_slab_cases();
    test_field_extremes();
    test_random_stream(750);
    test_tolerance_settings();
    drain_all();
    $display("Covered %0d beats: %0d hits, %0d misses, %0d bad boxes, %0d zero directions,",
             beats_taken, n_hit, n_miss, n_badbox, n_zerodir);
    $display("across zero, full-scale, random and default tolerance settings.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rosh_pkg.sv
design/rosh_front.sv
design/rosh_queue.sv
design/rosh_back.sv
design/ray_obb_slab_hit_test_core.sv
design/rosh_chk.sv
sim/ray_obb_slab_hit_test_core_tb.sv
